// File: hw/rtl/pin_puk_access_controller_top_defines.svh
// ---------------------------------------------------------------------------
// PIN/PUK access controller: assertion macros
// Shared assertion forms, clocked on clk_i and held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef PIN_PUK_ACCESS_CONTROLLER_TOP_DEFINES_SVH
`define PIN_PUK_ACCESS_CONTROLLER_TOP_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define PPAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define PPAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ppac_pkg.sv
// ---------------------------------------------------------------------------
// PIN/PUK access controller package
// Command codes, lock states, status codes and the queue/cipher-unit records.
// ---------------------------------------------------------------------------
package ppac_pkg;

  // Field widths
  localparam int unsigned CODE_BYTES = 8;
  localparam int unsigned CODE_W     = 8 * CODE_BYTES;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned TRIES_W    = 4;
  localparam int unsigned STATUS_W   = 3;

  // Header codes
  localparam logic [7:0] CLA_OK      = 8'hA0;
  localparam logic [7:0] INS_VERIFY  = 8'h20;
  localparam logic [7:0] INS_CHANGE  = 8'h24;
  localparam logic [7:0] INS_UNBLOCK = 8'h2C;
  localparam logic [7:0] INS_SETPUK  = 8'h40;

  // Cipher constants
  localparam int unsigned TEA_ROUNDS  = 32;
  localparam int unsigned RND_W       = $clog2(TEA_ROUNDS);
  localparam logic [31:0] TEA_DELTA   = 32'h9E3779B9;
  localparam logic [31:0] TEA_V0_INIT = 32'd1;
  localparam logic [31:0] TEA_V1_INIT = 32'd2;

  // PIN after set PUK: all ASCII '0'
  localparam logic [CODE_W-1:0] ZERO_PIN = {CODE_BYTES{8'h30}};

  localparam logic [TRIES_W-1:0] RETRY_RESET = 4'd3;

  typedef enum logic [1:0] {
    LS_VIRGIN   = 2'd0,
    LS_LOCKED   = 2'd1,
    LS_UNLOCKED = 2'd2,
    LS_BLOCKED  = 2'd3
  } lock_state_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_BAD_STATE = 3'd1,
    STS_BAD_LEN   = 3'd2,
    STS_BAD_PIN   = 3'd3,
    STS_BAD_PUK   = 3'd4,
    STS_BAD_CLASS = 3'd5
  } status_e;

  // Command class as decided by the front end
  typedef enum logic [2:0] {
    OP_BAD_CLASS,
    OP_BAD_INS,
    OP_VERIFY,
    OP_CHANGE,
    OP_UNBLOCK,
    OP_SETPUK
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_CIPHER
  } back_state_e;

  // Queue entry
  typedef struct packed {
    op_e               op;
    logic              len_ok;
    logic [CODE_W-1:0] first_code;
    logic [CODE_W-1:0] second_code;
  } cmd_t;

  // Cipher unit request and response
  typedef struct packed {
    logic              start;
    logic [CODE_W-1:0] puk;
  } tea_req_t;

  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] cipher;
  } tea_rsp_t;

  // Data length a command must declare
  function automatic logic [LEN_W-1:0] op_need_len(op_e op);
    logic [LEN_W-1:0] need;
    case (op) inside
      OP_CHANGE, OP_UNBLOCK: need = LEN_W'(2 * CODE_BYTES);
      default:               need = LEN_W'(CODE_BYTES);
    endcase
    return need;
  endfunction

  // Lock state a command must find
  function automatic lock_state_e op_need_state(op_e op);
    lock_state_e need;
    unique case (op)
      OP_VERIFY:  need = LS_LOCKED;
      OP_CHANGE:  need = LS_UNLOCKED;
      OP_UNBLOCK: need = LS_BLOCKED;
      default:    need = LS_VIRGIN;
    endcase
    return need;
  endfunction

endpackage

// File: hw/rtl/ppac_cmd_if.sv
// ---------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one card command per beat.
// ---------------------------------------------------------------------------
interface ppac_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  class_byte;
  logic [7:0]                  command;
  logic [7:0]                  length_byte;
  logic [ppac_pkg::CODE_W-1:0] first_code;
  logic [ppac_pkg::CODE_W-1:0] second_code;

  modport source (
    output valid, class_byte, command, length_byte, first_code, second_code,
    input  ready
  );
  modport sink (
    input  valid, class_byte, command, length_byte, first_code, second_code,
    output ready
  );
endinterface

// File: hw/rtl/ppac_rsp_if.sv
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one command result per beat.
// ---------------------------------------------------------------------------
interface ppac_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ppac_pkg::STATUS_W-1:0] status;
  logic [ppac_pkg::LEN_W-1:0]    expected_length;
  logic [ppac_pkg::TRIES_W-1:0]  tries_remaining;
  logic                          data_accepted;

  modport source (
    output valid, status, expected_length, tries_remaining, data_accepted,
    input  ready
  );
  modport sink (
    input  valid, status, expected_length, tries_remaining, data_accepted,
    output ready
  );
endinterface

// File: hw/rtl/ppac_cfg_if.sv
// ---------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the retry limit register.
// ---------------------------------------------------------------------------
interface ppac_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ppac_pkg::TRIES_W-1:0] retry_limit;

  modport source (output valid, retry_limit, input ready);
  modport sink   (input valid, retry_limit, output ready);
endinterface

// File: hw/rtl/ppac_front.sv
// ---------------------------------------------------------------------------
// PIN/PUK access controller front end
// Accepts command beats, decodes class and instruction, checks the declared
// length and pushes a classified entry into the command queue.
// ---------------------------------------------------------------------------
module ppac_front (
  ppac_cmd_if.sink         cmd_i,
  input  logic             q_full_i,
  output logic             push_o,
  output ppac_pkg::cmd_t   entry_o
);

  ppac_pkg::op_e op;

  // Class and instruction decode
  always_comb begin
    if (cmd_i.class_byte != ppac_pkg::CLA_OK) begin
      op = ppac_pkg::OP_BAD_CLASS;
    end else begin
      unique case (cmd_i.command)
        ppac_pkg::INS_VERIFY:  op = ppac_pkg::OP_VERIFY;
        ppac_pkg::INS_CHANGE:  op = ppac_pkg::OP_CHANGE;
        ppac_pkg::INS_UNBLOCK: op = ppac_pkg::OP_UNBLOCK;
        ppac_pkg::INS_SETPUK:  op = ppac_pkg::OP_SETPUK;
        default:               op = ppac_pkg::OP_BAD_INS;
      endcase
    end
  end

  // Entry build; the length only matters for a known instruction
  always_comb begin
    entry_o.op          = op;
    entry_o.len_ok      = (cmd_i.length_byte == 8'(ppac_pkg::op_need_len(op)));
    entry_o.first_code  = cmd_i.first_code;
    entry_o.second_code = cmd_i.second_code;
  end

  // Handshake: take a beat whenever the queue has room
  assign cmd_i.ready = !q_full_i;
  assign push_o      = cmd_i.valid && !q_full_i;

endmodule

// File: hw/rtl/ppac_queue.sv
// ---------------------------------------------------------------------------
// PIN/PUK access controller command queue
// Small FIFO of classified commands between the front end and the back end.
// ---------------------------------------------------------------------------
`include "pin_puk_access_controller_top_defines.svh"

module ppac_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ppac_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output ppac_pkg::cmd_t data_o,
  output logic           valid_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ppac_pkg::cmd_t  mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CW'(DEPTH));

  // Checks
  `PPAC_ASSERT(a_q_no_underflow, !pop_i || (cnt_q != '0), "queue popped while empty")
  `PPAC_ASSERT_NEXT(a_q_count_step, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "queue count did not follow a push")

endmodule

// File: hw/rtl/ppac_tea.sv
// ---------------------------------------------------------------------------
// PIN/PUK access controller cipher unit
// Iterative TEA encryption of the block {1,2} under a key built from the PUK,
// one full round per cycle.
// ---------------------------------------------------------------------------
`include "pin_puk_access_controller_top_defines.svh"

module ppac_tea (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppac_pkg::tea_req_t req_i,
  output ppac_pkg::tea_rsp_t rsp_o
);

  logic                       busy_q, done_q;
  logic [ppac_pkg::RND_W-1:0] rnd_q;
  logic [31:0]                v0_q, v1_q, sum_q;
  logic [3:0][31:0]           k_q;
  logic [3:0][31:0]           k_d;
  logic [31:0]                sum_n, v0_n, v1_n;

  // Key words: k[i] = b[2i] * 65536 + b[2i+1], b0 the top byte
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      k_d[i] = {8'h00, req_i.puk[ppac_pkg::CODE_W-1-16*i -: 8],
                8'h00, req_i.puk[ppac_pkg::CODE_W-9-16*i -: 8]};
    end
  end

  // One round
  always_comb begin
    sum_n = sum_q + ppac_pkg::TEA_DELTA;
    v0_n  = v0_q + (((v1_q << 4) + k_q[0]) ^ (v1_q + sum_n) ^ ((v1_q >> 5) + k_q[1]));
    v1_n  = v1_q + (((v0_n << 4) + k_q[2]) ^ (v0_n + sum_n) ^ ((v0_n >> 5) + k_q[3]));
  end

  // Round control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else if (busy_q) begin
      rnd_q <= rnd_q + 1'b1;
      if (rnd_q == ppac_pkg::RND_W'(ppac_pkg::TEA_ROUNDS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Cipher state
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      v0_q  <= ppac_pkg::TEA_V0_INIT;
      v1_q  <= ppac_pkg::TEA_V1_INIT;
      sum_q <= '0;
      k_q   <= k_d;
    end else if (busy_q) begin
      v0_q  <= v0_n;
      v1_q  <= v1_n;
      sum_q <= sum_n;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.cipher = {v0_q, v1_q};

  // Checks
  `PPAC_ASSERT(a_tea_no_restart, !(req_i.start && busy_q), "cipher started while busy")
  `PPAC_ASSERT(a_tea_full_rounds, !$rose(done_q) || ($past(rnd_q) == ppac_pkg::RND_W'(ppac_pkg::TEA_ROUNDS - 1)), "cipher finished early")

endmodule

// File: hw/rtl/ppac_back.sv
// ---------------------------------------------------------------------------
// PIN/PUK access controller back end
// Pops classified commands, checks lock state and length, compares codes,
// drives the cipher unit and updates PIN, PUK cipher, counter and lock state.
// Results go out through a registered response slot.
// ---------------------------------------------------------------------------
`include "pin_puk_access_controller_top_defines.svh"

module ppac_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  ppac_cfg_if.sink           cfg_i,
  input  ppac_pkg::cmd_t     head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  output ppac_pkg::tea_req_t tea_req_o,
  input  ppac_pkg::tea_rsp_t tea_rsp_i,
  ppac_rsp_if.source         rsp_o
);

  ppac_pkg::back_state_e          bk_state_q, bk_state_d;
  ppac_pkg::lock_state_e          lock_q, lock_d;
  logic [ppac_pkg::TRIES_W-1:0]   tries_q, tries_d;
  logic [ppac_pkg::TRIES_W-1:0]   limit_q;
  logic [ppac_pkg::CODE_W-1:0]    pin_q, pin_d;
  logic [ppac_pkg::CODE_W-1:0]    cipher_q, cipher_d;
  ppac_pkg::op_e                  pend_op_q;
  logic [ppac_pkg::CODE_W-1:0]    pend_pin_q;

  logic                           out_valid_q, out_valid_d;
  ppac_pkg::status_e              out_status_q, res_status;
  logic [ppac_pkg::LEN_W-1:0]     out_len_q, res_len;
  logic [ppac_pkg::TRIES_W-1:0]   out_tries_q, res_tries;
  logic                           out_acc_q, res_acc;

  logic                           slot_free;
  logic                           load;
  logic                           capture;
  logic                           pin_match;
  logic [ppac_pkg::TRIES_W-1:0]   tries_dec;

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign pin_match = (head_i.first_code == pin_q);
  assign tries_dec = (tries_q != '0) ? tries_q - 1'b1 : '0;

  // Next state
  always_comb begin
    bk_state_d = bk_state_q;
    unique case (bk_state_q)
      ppac_pkg::BK_IDLE:   if (tea_req_o.start) bk_state_d = ppac_pkg::BK_CIPHER;
      ppac_pkg::BK_CIPHER: if (load) bk_state_d = ppac_pkg::BK_IDLE;
      default:             bk_state_d = ppac_pkg::BK_IDLE;
    endcase
  end

  // Command execution and result build
  always_comb begin
    pop_o           = 1'b0;
    tea_req_o.start = 1'b0;
    tea_req_o.puk   = head_i.first_code;
    capture         = 1'b0;
    load            = 1'b0;
    res_status      = ppac_pkg::STS_OK;
    res_len         = '0;
    res_tries       = '0;
    res_acc         = 1'b0;
    lock_d          = lock_q;
    tries_d         = tries_q;
    pin_d           = pin_q;
    cipher_d        = cipher_q;
    unique case (bk_state_q)
      ppac_pkg::BK_IDLE: begin
        if (head_valid_i && slot_free) begin
          pop_o = 1'b1;
          if (head_i.op == ppac_pkg::OP_BAD_CLASS) begin
            load       = 1'b1;
            res_status = ppac_pkg::STS_BAD_CLASS;
          end else if (head_i.op == ppac_pkg::OP_BAD_INS) begin
            load       = 1'b1;
            res_status = ppac_pkg::STS_BAD_STATE;
          end else if (lock_q != ppac_pkg::op_need_state(head_i.op)) begin
            load       = 1'b1;
            res_status = ppac_pkg::STS_BAD_STATE;
          end else if (!head_i.len_ok) begin
            load       = 1'b1;
            res_status = ppac_pkg::STS_BAD_LEN;
            res_len    = ppac_pkg::op_need_len(head_i.op);
          end else begin
            res_acc = 1'b1;
            unique case (head_i.op) inside
              ppac_pkg::OP_VERIFY, ppac_pkg::OP_CHANGE: begin
                load = 1'b1;
                if (!pin_match) begin
                  // wrong PIN: spend a try, block at zero
                  tries_d    = tries_dec;
                  res_status = ppac_pkg::STS_BAD_PIN;
                  res_tries  = tries_dec;
                  if (tries_dec == '0) lock_d = ppac_pkg::LS_BLOCKED;
                end else if (head_i.op == ppac_pkg::OP_VERIFY) begin
                  lock_d = ppac_pkg::LS_UNLOCKED;
                end else begin
                  tries_d = limit_q;
                  pin_d   = head_i.second_code;
                end
              end
              ppac_pkg::OP_SETPUK, ppac_pkg::OP_UNBLOCK: begin
                tea_req_o.start = 1'b1;
                capture         = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      ppac_pkg::BK_CIPHER: begin
        if (tea_rsp_i.done && slot_free) begin
          load    = 1'b1;
          res_acc = 1'b1;
          if (pend_op_q == ppac_pkg::OP_SETPUK) begin
            cipher_d = tea_rsp_i.cipher;
            pin_d    = ppac_pkg::ZERO_PIN;
            tries_d  = limit_q;
            lock_d   = ppac_pkg::LS_LOCKED;
          end else if (tea_rsp_i.cipher == cipher_q) begin
            pin_d   = pend_pin_q;
            tries_d = limit_q;
            lock_d  = ppac_pkg::LS_LOCKED;
          end else begin
            res_status = ppac_pkg::STS_BAD_PUK;
          end
        end
      end
      default: ;
    endcase
  end

  // Response slot: free when empty or being taken this cycle
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bk_state_q  <= ppac_pkg::BK_IDLE;
      lock_q      <= ppac_pkg::LS_VIRGIN;
      tries_q     <= '0;
      limit_q     <= ppac_pkg::RETRY_RESET;
      out_valid_q <= 1'b0;
    end else begin
      bk_state_q  <= bk_state_d;
      lock_q      <= lock_d;
      tries_q     <= tries_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        limit_q <= cfg_i.retry_limit;
      end
    end
  end

  // Stored codes, pending command and result payload
  always_ff @(posedge clk_i) begin
    pin_q    <= pin_d;
    cipher_q <= cipher_d;
    if (capture) begin
      pend_op_q  <= head_i.op;
      pend_pin_q <= head_i.second_code;
    end
    if (load) begin
      out_status_q <= res_status;
      out_len_q    <= res_len;
      out_tries_q  <= res_tries;
      out_acc_q    <= res_acc;
    end
  end

  assign cfg_i.ready           = 1'b1;
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.expected_length = out_len_q;
  assign rsp_o.tries_remaining = out_tries_q;
  assign rsp_o.data_accepted   = out_acc_q;

  // Checks
  `PPAC_ASSERT_NEXT(a_bk_hold_in_cipher, (bk_state_q == ppac_pkg::BK_CIPHER) && !tea_rsp_i.done, $stable(lock_q) && $stable(tries_q), "card state moved while cipher runs")
  `PPAC_ASSERT_NEXT(a_bk_blocked_exit, lock_q == ppac_pkg::LS_BLOCKED, (lock_q == ppac_pkg::LS_BLOCKED) || (lock_q == ppac_pkg::LS_LOCKED), "blocked card left by a path other than unblock")

endmodule

// File: hw/rtl/pin_puk_access_controller_top.sv
// ---------------------------------------------------------------------------
// PIN/PUK access controller top level
// Front end, command queue, back end and cipher unit.
// ---------------------------------------------------------------------------
// Verify, change and rejected commands are answered through the queue and
// the registered response slot. Set PUK and unblock also wait for the cipher
// unit (one TEA round per cycle, 32 rounds). Non-cipher beats are taken one
// per cycle while responses are taken; set PUK or unblock holds the back end
// until the cipher is done. Reset: lock state virgin, counter 0, retry limit 3.
module pin_puk_access_controller_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppac_cmd_if.sink   cmd_i,
  ppac_cfg_if.sink   cfg_i,
  ppac_rsp_if.source rsp_o
);

  logic               push;
  logic               q_full;
  logic               pop;
  logic               head_valid;
  ppac_pkg::cmd_t     entry;
  ppac_pkg::cmd_t     head;
  ppac_pkg::tea_req_t tea_req;
  ppac_pkg::tea_rsp_t tea_rsp;

  // Classify incoming commands
  ppac_front u_front (
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (entry)
  );

  // Decoupling queue
  ppac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (head),
    .valid_o (head_valid)
  );

  // PUK cipher
  ppac_tea u_tea (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tea_req),
    .rsp_o  (tea_rsp)
  );

  // Execute commands
  ppac_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .tea_req_o    (tea_req),
    .tea_rsp_i    (tea_rsp),
    .rsp_o        (rsp_o)
  );

endmodule
